// File: src/ccb_pkg.sv
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared types and constants of the clipped color-key blitter.
// ----------------------------------------------------------------------------
package ccb_pkg;

    // Largest source side; the position counters wrap here at the latest.
    localparam int MAX_SIDE = 4096;
    localparam int CNT_W    = $clog2(MAX_SIDE);

    // Register, pixel and index widths.
    localparam int REG_W    = 13;
    localparam int PIX_W    = 32;
    localparam int IDX_W    = 24;
    localparam int CIDX_W   = 3;

    // Signed destination position: offset plus counter, with sign bit.
    localparam int POS_W    = ((CNT_W > REG_W) ? CNT_W : REG_W) + 2;
    // Width for counter wrap compares against register and MAX_SIDE.
    localparam int CMP_W    = ((CNT_W + 1 > REG_W) ? CNT_W + 1 : REG_W) + 1;
    localparam int PROD_W   = 2 * REG_W;

    // Transparency key: a pixel with all these bits set is dropped.
    localparam logic [PIX_W-1:0] KEY_MASK = 32'h00c9_0280;

    // Queue between classifier and index unit.
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    typedef enum logic [CIDX_W-1:0] {
        CFG_DEST_WIDTH    = 3'd0,
        CFG_DEST_HEIGHT   = 3'd1,
        CFG_DEST_STRIDE   = 3'd2,
        CFG_SOURCE_WIDTH  = 3'd3,
        CFG_SOURCE_HEIGHT = 3'd4,
        CFG_OFFSET_X      = 3'd5,
        CFG_OFFSET_Y      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [REG_W-1:0] dest_width;
        logic [REG_W-1:0] dest_height;
        logic [REG_W-1:0] dest_stride;
        logic [REG_W-1:0] source_width;
        logic [REG_W-1:0] source_height;
        logic [REG_W-1:0] offset_x;
        logic [REG_W-1:0] offset_y;
    } t_ccb_cfg;

    // A pixel that survived clipping and keying, with its destination spot.
    typedef struct packed {
        logic [REG_W-1:0] dy;
        logic [REG_W-1:0] dx;
        logic [PIX_W-1:0] pixel;
    } t_ccb_entry;

endpackage

// File: src/ccb_front.sv
// ----------------------------------------------------------------------------
// ccb_front
// Source position counters, clip test and color-key test.
// ----------------------------------------------------------------------------
module ccb_front import ccb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ccb_cfg         i_cfg,
    input  logic             i_in_valid,
    input  logic [PIX_W-1:0] i_pixel_in,
    input  logic             i_q_full,
    output logic             o_in_ready,
    output logic             o_push,
    output t_ccb_entry       o_entry
);

    logic [CNT_W-1:0]        r_col;
    logic [CNT_W-1:0]        r_row;
    logic [CNT_W-1:0]        n_col;
    logic [CNT_W-1:0]        n_row;
    logic [CMP_W-1:0]        col_inc;
    logic [CMP_W-1:0]        row_inc;
    logic                    col_wrap;
    logic                    row_wrap;
    logic signed [POS_W-1:0] dx;
    logic signed [POS_W-1:0] dy;
    logic                    in_x;
    logic                    in_y;
    logic                    keyed;
    logic                    accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Destination position = signed offset + source position.
    assign dx = $signed({{(POS_W-REG_W){i_cfg.offset_x[REG_W-1]}}, i_cfg.offset_x})
              + $signed({{(POS_W-CNT_W){1'b0}}, r_col});
    assign dy = $signed({{(POS_W-REG_W){i_cfg.offset_y[REG_W-1]}}, i_cfg.offset_y})
              + $signed({{(POS_W-CNT_W){1'b0}}, r_row});

    assign in_x  = !dx[POS_W-1] && (dx[POS_W-2:0] < (POS_W-1)'(i_cfg.dest_width));
    assign in_y  = !dy[POS_W-1] && (dy[POS_W-2:0] < (POS_W-1)'(i_cfg.dest_height));
    assign keyed = (i_pixel_in & KEY_MASK) == KEY_MASK;

    assign o_push        = accept && in_x && in_y && !keyed;
    assign o_entry.dx    = dx[REG_W-1:0];
    assign o_entry.dy    = dy[REG_W-1:0];
    assign o_entry.pixel = i_pixel_in;

    // Wrap at source size or MAX_SIDE; a size of 0 behaves as 1.
    always_comb begin
        col_inc  = CMP_W'(r_col) + CMP_W'(1);
        row_inc  = CMP_W'(r_row) + CMP_W'(1);
        col_wrap = (col_inc >= CMP_W'(i_cfg.source_width)) || (col_inc >= CMP_W'(MAX_SIDE));
        row_wrap = (row_inc >= CMP_W'(i_cfg.source_height)) || (row_inc >= CMP_W'(MAX_SIDE));
        n_col    = col_wrap ? '0 : col_inc[CNT_W-1:0];
        n_row    = r_row;
        if (col_wrap) begin
            n_row = row_wrap ? '0 : row_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

`ifndef SYNTH
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_col == '0) || (r_col == $past(r_col) + CNT_W'(1)))
        else $error("column counter skipped");
    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !col_wrap) |=> (r_row == $past(r_row)))
        else $error("row moved without column wrap");
    a_no_push_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (in_x && in_y && !keyed && !i_q_full))
        else $error("clipped or keyed pixel pushed");
`endif

endmodule

// File: src/ccb_queue.sv
// ----------------------------------------------------------------------------
// ccb_queue
// Short FIFO of surviving pixels between classifier and index unit.
// ----------------------------------------------------------------------------
module ccb_queue import ccb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_ccb_entry i_entry,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_ccb_entry o_entry
);

    t_ccb_entry        r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;

    assign o_full  = r_count == Q_CW'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// File: src/ccb_back.sv
// ----------------------------------------------------------------------------
// ccb_back
// Index unit: row * stride + column, into the output register.
// ----------------------------------------------------------------------------
module ccb_back import ccb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [REG_W-1:0] i_dest_stride,
    input  logic             i_q_valid,
    input  t_ccb_entry       i_entry,
    input  logic             i_out_ready,
    output logic             o_pop,
    output logic             o_out_valid,
    output logic [IDX_W-1:0] o_dest_index,
    output logic [PIX_W-1:0] o_pixel_out
);

    logic              r_valid;
    logic [IDX_W-1:0]  r_index;
    logic [PIX_W-1:0]  r_pixel;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum;

    assign prod  = PROD_W'(i_entry.dy) * PROD_W'(i_dest_stride);
    assign sum   = prod + PROD_W'(i_entry.dx);
    assign o_pop = i_q_valid && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_index <= sum[IDX_W-1:0];
            r_pixel <= i_entry.pixel;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_dest_index = r_index;
    assign o_pixel_out  = r_pixel;

endmodule

// File: src/clipped_color_key_blitter.sv
// ----------------------------------------------------------------------------
// clipped_color_key_blitter
// Places raster-order source pixels into a clipped destination, drops
// color-keyed pixels and emits one indexed write per surviving pixel.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | sink      | i_in_valid / o_in_ready | i_pixel_in
//  out     | source    | o_out_valid/i_out_ready | o_dest_index, o_pixel_out
//  cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One pixel transaction per clock sustained while the queue is not full;
//  a written pixel reaches the output through a queue slot and then the
//  output register. The front classifies a pixel in its accept cycle; the
//  back does one 13x13 multiply-add per cycle when not stalled; a 4-entry
//  queue between them absorbs output stalls; input stalls only when that
//  queue is full. Synchronous active-low reset clears counters, queue and
//  output valid and loads the register defaults; no clearing pass is needed.
//
module clipped_color_key_blitter import ccb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input pixels
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [PIX_W-1:0]  i_pixel_in,
    // output writes
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [IDX_W-1:0]  o_dest_index,
    output logic [PIX_W-1:0]  o_pixel_out,
    // register writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]  i_cfg_data
);

    t_ccb_cfg   r_cfg;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_valid;
    t_ccb_entry push_entry;
    t_ccb_entry head_entry;

    // Register file always takes a write; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_width    <= REG_W'(1);
            r_cfg.dest_height   <= REG_W'(1);
            r_cfg.dest_stride   <= REG_W'(1);
            r_cfg.source_width  <= REG_W'(1);
            r_cfg.source_height <= REG_W'(1);
            r_cfg.offset_x      <= '0;
            r_cfg.offset_y      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEST_WIDTH:    r_cfg.dest_width    <= i_cfg_data;
                CFG_DEST_HEIGHT:   r_cfg.dest_height   <= i_cfg_data;
                CFG_DEST_STRIDE:   r_cfg.dest_stride   <= i_cfg_data;
                CFG_SOURCE_WIDTH:  r_cfg.source_width  <= i_cfg_data;
                CFG_SOURCE_HEIGHT: r_cfg.source_height <= i_cfg_data;
                CFG_OFFSET_X:      r_cfg.offset_x      <= i_cfg_data;
                CFG_OFFSET_Y:      r_cfg.offset_y      <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // Front: counters plus clip/key decision, pushes survivors only.
    ccb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_pixel_in (i_pixel_in),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // Decoupling queue.
    ccb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    // Back: index multiply-add and output register.
    ccb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dest_stride (r_cfg.dest_stride),
        .i_q_valid     (q_valid),
        .i_entry       (head_entry),
        .i_out_ready   (i_out_ready),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_dest_index  (o_dest_index),
        .o_pixel_out   (o_pixel_out)
    );

endmodule

// File: dv/clipped_color_key_blitter_tb.sv
// ----------------------------------------------------------------------------
// clipped_color_key_blitter_tb
// Self-checking bench for the clipped color-key blitter. Raster pixels go in
// on a valid/ready channel while a local model tracks the source position,
// the clip rectangle and the transparency key. Every write that comes out is
// compared with the oldest predicted write. Directed cases cover defaults,
// clipping on all four sides, zero sizes and stride, index wrap and unknown
// registers. They are followed by a long output stall, source sides above
// the maximum, and randomized geometry phases with idle bursts on both
// sides.
// ----------------------------------------------------------------------------
module clipped_color_key_blitter_tb;
    import ccb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int DRAIN_CYCLES = 4;        // output lags acceptance by queue slot and output register
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SWEEP_LEN    = 64;

    // Index 7 decodes to no register.
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;

    // One expected destination write.
    typedef struct {
        logic [IDX_W-1:0] dest_index;
        logic [PIX_W-1:0] pixel;
    } blit_write_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [PIX_W-1:0]  pixel_in  = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [IDX_W-1:0]  dest_index;
    logic [PIX_W-1:0]  pixel_out;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]  cfg_data  = '0;

    clipped_color_key_blitter i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_pixel_in   (pixel_in),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_dest_index (dest_index),
        .o_pixel_out  (pixel_out),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_ccb_cfg          geom;             // model copy of the register file
    logic [CNT_W-1:0]  col_pos;          // model source column
    logic [CNT_W-1:0]  row_pos;          // model source row
    blit_write_t       pending_writes[$];
    int                mismatches  = 0;
    int                cycle_count = 0;
    bit                tx_idle_en  = 1'b1;
    bit                rx_idle_en  = 1'b1;
    bit                hold_req    = 1'b0;

    // ------------------------------------------------------------------------
    // Position model
    // ------------------------------------------------------------------------
    // Counter step: wraps at the register limit or at MAX_SIDE, whichever is
    // hit first. A limit of zero wraps every time, so it acts as one.
    function automatic logic [CNT_W-1:0] step_count(input logic [CNT_W-1:0] cur,
                                                    input logic [REG_W-1:0] lim,
                                                    output bit wrapped);
        int unsigned nxt;
        nxt = cur + 1;
        wrapped = (nxt >= lim) || (nxt >= MAX_SIDE);
        return wrapped ? '0 : nxt[CNT_W-1:0];
    endfunction

    // Called on every accepted pixel: queues the write it should cause (if
    // it lands inside the destination and is not keyed out), then moves the
    // source position on regardless.
    task automatic place_pixel(input logic [PIX_W-1:0] px);
        logic signed [REG_W-1:0] off_x;
        logic signed [REG_W-1:0] off_y;
        int          dx;
        int          dy;
        longint      idx;
        bit          wrap;
        blit_write_t w;
        off_x = geom.offset_x;
        off_y = geom.offset_y;
        dx = off_x + int'(col_pos);
        dy = off_y + int'(row_pos);
        if (dx >= 0 && dy >= 0 &&
            dx < int'(geom.dest_width) && dy < int'(geom.dest_height) &&
            ((px & KEY_MASK) != KEY_MASK)) begin
            idx = longint'(dy) * longint'(geom.dest_stride) + longint'(dx);
            w.dest_index = idx[IDX_W-1:0];  // index keeps its low 24 bits
            w.pixel      = px;
            pending_writes.push_back(w);
        end
        col_pos = step_count(col_pos, geom.source_width, wrap);
        if (wrap) begin
            row_pos = step_count(row_pos, geom.source_height, wrap);
        end
    endtask

    task automatic apply_reg(input logic [CIDX_W-1:0] idx, input logic [REG_W-1:0] val);
        case (idx)
            CFG_DEST_WIDTH:    geom.dest_width    = val;
            CFG_DEST_HEIGHT:   geom.dest_height   = val;
            CFG_DEST_STRIDE:   geom.dest_stride   = val;
            CFG_SOURCE_WIDTH:  geom.source_width  = val;
            CFG_SOURCE_HEIGHT: geom.source_height = val;
            CFG_OFFSET_X:      geom.offset_x      = val;
            CFG_OFFSET_Y:      geom.offset_y      = val;
            default: ;                      // unknown index: no effect
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One pixel transaction, optionally preceded by an idle burst. Valid is
    // only changed at falling edges and stays high until accepted.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        pixel_in <= px;
        do @(posedge i_clk); while (!in_ready);
        place_pixel(px);
    endtask

    // Register write; only issued while the block is drained.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering pixels, wait for every expected write, then let the
    // pipeline settle in case the last pixels were all dropped.
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [REG_W-1:0] dw, input logic [REG_W-1:0] dh,
                                input logic [REG_W-1:0] ds, input logic [REG_W-1:0] sw,
                                input logic [REG_W-1:0] sh, input logic [REG_W-1:0] ox,
                                input logic [REG_W-1:0] oy);
        wait_drained();
        write_reg(CFG_DEST_WIDTH,    dw);
        write_reg(CFG_DEST_HEIGHT,   dh);
        write_reg(CFG_DEST_STRIDE,   ds);
        write_reg(CFG_SOURCE_WIDTH,  sw);
        write_reg(CFG_SOURCE_HEIGHT, sh);
        write_reg(CFG_OFFSET_X,      ox);
        write_reg(CFG_OFFSET_Y,      oy);
    endtask

    // Receiver: random stall bursts, plus the long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every output transaction against the oldest expected write
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        blit_write_t w;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected write: dest_index %0h pixel_out %0h",
                       dest_index, pixel_out);
                mismatches++;
            end else begin
                w = pending_writes.pop_front();
                if (dest_index !== w.dest_index) begin
                    $error("dest_index: expected %0h, got %0h", w.dest_index, dest_index);
                    mismatches++;
                end
                if (pixel_out !== w.pixel) begin
                    $error("pixel_out: expected %0h, got %0h", w.pixel, pixel_out);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("clipped_color_key_blitter_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mix of plain pixels, fully keyed pixels and near misses of the key.
    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] px;
        int               b;
        px = $urandom;
        case ($urandom_range(0, 3))
            0: px = px | KEY_MASK;
            1: begin
                px = px | KEY_MASK;
                do b = $urandom_range(0, PIX_W - 1); while (!KEY_MASK[b]);
                px[b] = 1'b0;
            end
            default: ;
        endcase
        return px;
    endfunction

    // Sizes: mostly small, sometimes zero, MAX_SIDE, the 13-bit top or random.
    function automatic logic [REG_W-1:0] rand_size(input int hi);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return REG_W'(MAX_SIDE);
            3:       return REG_W'($urandom);
            default: return REG_W'($urandom_range(1, hi));
        endcase
    endfunction

    function automatic logic [REG_W-1:0] rand_offset();
        case ($urandom_range(0, 9))
            0:       return 13'h1000;       // most negative
            1:       return 13'h0fff;       // most positive
            2:       return REG_W'($urandom);
            default: return REG_W'($urandom_range(0, 10) - 4);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset geometry is 1x1 at offset 0: unkeyed pixels land on index 0.
    task automatic test_reset_defaults();
        send_pixel('0);
        send_pixel('1);                     // all key bits set: dropped
        send_pixel(KEY_MASK);               // exactly the key: dropped
        send_pixel(KEY_MASK ^ 32'h0000_0080); // one key bit missing: written
        send_pixel(32'h1234_5678);
    endtask

    // 3x3 source over a 1x1 destination at (-1,-1): clips left, right, top
    // and bottom; only the center pixel survives.
    task automatic test_clipping();
        set_geometry(13'd1, 13'd1, 13'd5, 13'd3, 13'd3, 13'h1fff, 13'h1fff);
        repeat (9) send_pixel($urandom & ~KEY_MASK);
    endtask

    task automatic test_zero_sizes();
        // zero destination width drops everything
        set_geometry(13'd0, 13'd4, 13'd4, 13'd2, 13'd1, 13'd0, 13'd0);
        repeat (2) send_pixel($urandom & ~KEY_MASK);
        // zero source size acts as one, zero stride gives index = column
        set_geometry(13'd4, 13'd4, 13'd0, 13'd0, 13'd0, 13'd3, 13'd0);
        repeat (2) send_pixel($urandom & ~KEY_MASK);
        // zero stride with the row moving
        set_geometry(13'd4, 13'd4, 13'd0, 13'd1, 13'd2, 13'd3, 13'd1);
        repeat (2) send_pixel($urandom & ~KEY_MASK);
    endtask

    // Largest row times largest stride overflows the 24-bit index.
    task automatic test_index_overflow();
        set_geometry('1, '1, '1, 13'd1, 13'd1, 13'h0fff, 13'h0fff);
        send_pixel(32'hdead_beef);
    endtask

    task automatic test_unknown_register();
        wait_drained();
        write_reg(CFG_UNUSED, '1);
        send_pixel(32'h0f0f_0f0f);
    endtask

    // Receiver holds off while the sender keeps going: the internal queue
    // fills and the input channel has to stall.
    task automatic test_backpressure();
        set_geometry(13'd8, 13'd8, 13'd8, 13'd4, 13'd4, 13'd0, 13'd0);
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (40) send_pixel($urandom & ~KEY_MASK);
        tx_idle_en = 1'b1;
    endtask

    // Source sides above MAX_SIDE: a long run along one row, then a long
    // run down one column, with the other counter held.
    task automatic test_large_source();
        tx_idle_en = 1'b0;
        set_geometry('1, '1, REG_W'($urandom_range(0, 20)), '1, 13'd2,
                     REG_W'($urandom_range(0, 3)), 13'd0);
        repeat (SWEEP_LEN) send_pixel(rand_pixel());
        set_geometry(13'd2, '1, '1, 13'd1, '1, 13'd0, REG_W'($urandom_range(0, 3)));
        repeat (SWEEP_LEN) send_pixel(rand_pixel());
        tx_idle_en = 1'b1;
    endtask

    // Random geometry per phase; idling on either side per phase when allowed.
    task automatic test_random_phases(input int n_phases, input int per_phase,
                                      input bit idle_ok);
        int n;
        for (int p = 0; p < n_phases; p++) begin
            set_geometry(rand_size(10), rand_size(10), rand_size(12),
                         rand_size(8), rand_size(8), rand_offset(), rand_offset());
            if ($urandom_range(0, 5) == 0) begin
                write_reg(CFG_UNUSED, REG_W'($urandom));
            end
            tx_idle_en = idle_ok && ($urandom_range(0, 2) != 0);
            rx_idle_en = idle_ok && ($urandom_range(0, 2) != 0);
            n = $urandom_range(per_phase / 2, per_phase * 3 / 2);
            repeat (n) send_pixel(rand_pixel());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        geom.dest_width    = 13'd1;
        geom.dest_height   = 13'd1;
        geom.dest_stride   = 13'd1;
        geom.source_width  = 13'd1;
        geom.source_height = 13'd1;
        geom.offset_x      = '0;
        geom.offset_y      = '0;
        col_pos = '0;
        row_pos = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_clipping();
        test_zero_sizes();
        test_index_overflow();
        test_unknown_register();
        test_backpressure();
        test_large_source();
        test_random_phases(20, 40, 1'b1);
        test_random_phases(3, 30, 1'b0);    // closing stretch without idling

        wait_drained();
        if (mismatches == 0) begin
            $display("clipped_color_key_blitter_tb passed");
        end else begin
            $display("clipped_color_key_blitter_tb failed");
        end
        $finish;
    end

endmodule
